FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared constants, codes and types of the max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

	localparam int CAPACITY = 128;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = ADDR_W + 1;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_EXTRACTED = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UP_CMP,
		ST_UP_FIN,
		ST_EX_LOAD,
		ST_DN_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [15:0] severity;
		logic [15:0] task_id;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} wr_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} rd_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/mhpq_ram.sv
// ----------------------------------------------------------------------------
// mhpq_ram
// Heap entry store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram (
	input  wire logic             clk,
	input  wire mhpq_pkg::wr_req_t wr,
	input  wire mhpq_pkg::rd_req_t rd,
	output mhpq_pkg::entry_t      rd_a,
	output mhpq_pkg::entry_t      rd_b
);
	import mhpq_pkg::*;

	entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_a <= mem[rd.addr_a];
		rd_b <= mem[rd.addr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/core/max_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// Binary max-heap priority queue of (task id, severity) entries in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_axis   in   tuser: func | tdata: task_id[15:0], severity[31:16]
//  m_axis   out  tuser: status | tdata: out_id[15:0], out_severity[31:16],
//                occupancy[39:32]
//
//  Insert: the new entry climbs from the last slot, one severity compare per
//  level against its parent; extract: root and last entry are loaded, then the
//  entry descends, one compare per level against the larger child, each compare
//  using a registered RAM read. A dropped insert or an empty extract ends at once.
//  The moving entry rides in a register and is written once at its final slot.
//  Reset empties the heap at once; no clearing pass. One item is worked at a
//  time; a new item is taken while the previous result waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // task_id, severity
	input  wire logic [0:0]  s_axis_tuser,  // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // out_id, out_severity, occupancy
	output logic [1:0]       m_axis_tuser   // status
);
	import mhpq_pkg::*;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_m1;
	logic [ADDR_W-1:0]  pos_q, pos_d, par_q, par_d;
	entry_t             mov_q, mov_d, res_ent_q, res_ent_d;
	status_t            res_status_q, res_status_d;
	logic               m_valid_q;
	status_t            m_status_q;
	entry_t             m_ent_q;
	logic [7:0]         m_occ_q;

	wr_req_t            wr;
	rd_req_t            rd;
	entry_t             rd_a, rd_b, in_ent, child_ent;

	logic               accept, out_free, is_full, heap_empty;
	logic               up_go, take_l, take_r, dn_go;
	logic [15:0]        best_sev;
	logic [CHILD_W-1:0] lc, rc, nlc, nrc, cnt_ext;
	logic [ADDR_W-1:0]  dn_idx, par_of_cnt, par_up;
	logic [CNT_W-1:0]   cnt_m1_half;

	mhpq_ram u_ram (
		.clk  (clk),
		.wr   (wr),
		.rd   (rd),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign in_ent        = '{severity: s_axis_tdata[31:16], task_id: s_axis_tdata[15:0]};

	assign is_full     = (cnt_q == CNT_W'(CAPACITY));
	assign heap_empty  = (cnt_q == '0);
	assign cnt_m1      = cnt_q - CNT_W'(1);
	assign cnt_m1_half = cnt_m1 >> 1;
	assign par_of_cnt  = cnt_m1_half[ADDR_W-1:0];
	assign par_up      = (par_q - ADDR_W'(1)) >> 1;

	assign up_go = mov_q.severity > rd_a.severity;

	assign cnt_ext   = CHILD_W'(cnt_q);
	assign lc        = {pos_q, 1'b1};
	assign rc        = lc + CHILD_W'(1);
	assign take_l    = (lc < cnt_ext) && (rd_a.severity > mov_q.severity);
	assign best_sev  = take_l ? rd_a.severity : mov_q.severity;
	assign take_r    = (rc < cnt_ext) && (rd_b.severity > best_sev);
	assign dn_go     = take_l || take_r;
	assign dn_idx    = take_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
	assign child_ent = take_r ? rd_b : rd_a;
	assign nlc       = {dn_idx, 1'b1};
	assign nrc       = nlc + CHILD_W'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser[0] == FUNC_INSERT) begin
						if (is_full)
							state_d = ST_DONE;
						else if (heap_empty)
							state_d = ST_UP_FIN;
						else
							state_d = ST_UP_CMP;
					end else begin
						state_d = heap_empty ? ST_DONE : ST_EX_LOAD;
					end
				end
			end
			ST_UP_CMP: begin
				if (!up_go)
					state_d = ST_DONE;
				else if (par_q == '0)
					state_d = ST_UP_FIN;
			end
			ST_UP_FIN:  state_d = ST_DONE;
			ST_EX_LOAD: state_d = heap_empty ? ST_DONE : ST_DN_CMP;
			ST_DN_CMP: begin
				if (!dn_go)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cnt_d        = cnt_q;
		pos_d        = pos_q;
		par_d        = par_q;
		mov_d        = mov_q;
		res_ent_d    = res_ent_q;
		res_status_d = res_status_q;
		wr.en        = 1'b0;
		wr.addr      = pos_q;
		wr.data      = mov_q;
		rd.addr_a    = (s_axis_tuser[0] == FUNC_EXTRACT) ? '0 : par_of_cnt;
		rd.addr_b    = cnt_m1[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_ent_d = '0;
					if (s_axis_tuser[0] == FUNC_INSERT) begin
						if (is_full) begin
							res_status_d = STAT_FULL;
						end else begin
							res_status_d = STAT_INSERTED;
							cnt_d        = cnt_q + CNT_W'(1);
							mov_d        = in_ent;
							pos_d        = cnt_q[ADDR_W-1:0];
							par_d        = par_of_cnt;
						end
					end else begin
						if (heap_empty) begin
							res_status_d = STAT_EMPTY;
						end else begin
							res_status_d = STAT_EXTRACTED;
							cnt_d        = cnt_m1;
						end
					end
				end
			end
			ST_UP_CMP: begin
				wr.en     = 1'b1;
				rd.addr_a = par_up;
				if (up_go) begin
					wr.data = rd_a;
					pos_d   = par_q;
					par_d   = par_up;
				end
			end
			ST_UP_FIN: begin
				wr.en = 1'b1;
			end
			ST_EX_LOAD: begin
				res_ent_d = rd_a;
				mov_d     = rd_b;
				pos_d     = '0;
				rd.addr_a = ADDR_W'(1);
				rd.addr_b = ADDR_W'(2);
			end
			ST_DN_CMP: begin
				wr.en     = 1'b1;
				rd.addr_a = nlc[ADDR_W-1:0];
				rd.addr_b = nrc[ADDR_W-1:0];
				if (dn_go) begin
					wr.data = child_ent;
					pos_d   = dn_idx;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		par_q        <= par_d;
		mov_q        <= mov_d;
		res_ent_q    <= res_ent_d;
		res_status_q <= res_status_d;
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= res_status_q;
			m_ent_q    <= res_ent_q;
			m_occ_q    <= 8'(cnt_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {m_occ_q, m_ent_q.severity, m_ent_q.task_id};

endmodule

`default_nettype wire

FILE: rtl/core/mhpq_chk.sv
// ----------------------------------------------------------------------------
// mhpq_chk
// Port-level checks on the priority queue's input handshake and result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mhpq_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);
	import mhpq_pkg::*;

	logic in_beat;
	logic stalled;

	assign in_beat = s_axis_tvalid && s_axis_tready;
	assign stalled = m_axis_tvalid && !m_axis_tready;

	`ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_beat, !s_axis_tready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`ASSERT_IMPLY(a_zero_payload, clk, arst_n, m_axis_tvalid && (m_axis_tuser != STAT_EXTRACTED), m_axis_tdata[31:0] == 32'd0)
	`ASSERT_IMPLY(a_empty_occ, clk, arst_n, m_axis_tvalid && (m_axis_tuser == STAT_EMPTY), m_axis_tdata[39:32] == 8'd0)
	`ASSERT_IMPLY(a_full_occ, clk, arst_n, m_axis_tvalid && (m_axis_tuser == STAT_FULL), m_axis_tdata[39:32] == 8'(CAPACITY))

endmodule

bind max_heap_priority_queue_unit mhpq_chk u_mhpq_chk (.*);

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams insert and extract beats into the max-heap priority queue, predicts
// every result with a behavioral heap and checks status, id, severity and
// occupancy per result, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import mhpq_pkg::*;

	localparam int NUM_OPS     = 1200;
	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_LO    = 2000;
	localparam int QUIET_HI    = 6000;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_LEN    = 400;
	localparam int DRAIN_WAIT  = 20;

	typedef struct {
		logic        func;
		logic [15:0] task_id;
		logic [15:0] severity;
		bit          settle;
	} heap_op_t;

	typedef struct {
		status_t     status;
		logic [15:0] out_id;
		logic [15:0] out_severity;
		logic [7:0]  occupancy;
	} heap_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;  // task_id, severity
	logic [0:0]  s_axis_tuser  = '0;  // func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // out_id, out_severity, occupancy
	logic [1:0]  m_axis_tuser;        // status

	heap_op_t     pending_ops[$];
	heap_result_t expected_results[$];

	entry_t heap_mem [CAPACITY];
	int     heap_count = 0;
	int     plan_count = 0;

	int sent_count   = 0;
	int done_count   = 0;
	int err_count    = 0;
	int cycle_count  = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;

	heap_op_t     next_op;
	heap_result_t predicted;
	heap_result_t oldest;

	max_heap_priority_queue_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	task automatic predict_heap(input logic func, input logic [15:0] task_id,
			input logic [15:0] severity, output heap_result_t r);
		int     pos;
		int     up;
		int     best;
		int     lc;
		int     rc;
		entry_t tmp;
		r.status       = STAT_INSERTED;
		r.out_id       = '0;
		r.out_severity = '0;
		if (func == FUNC_INSERT) begin
			if (heap_count >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				heap_mem[heap_count].severity = severity;
				heap_mem[heap_count].task_id  = task_id;
				pos = heap_count;
				while (pos != 0) begin
					up = (pos - 1) / 2;
					if (heap_mem[pos].severity <= heap_mem[up].severity)
						break;
					tmp           = heap_mem[pos];
					heap_mem[pos] = heap_mem[up];
					heap_mem[up]  = tmp;
					pos           = up;
				end
				heap_count++;
			end
		end else begin
			if (heap_count == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				r.status       = STAT_EXTRACTED;
				r.out_id       = heap_mem[0].task_id;
				r.out_severity = heap_mem[0].severity;
				heap_count--;
				heap_mem[0] = heap_mem[heap_count];
				pos = 0;
				while (pos < heap_count) begin
					best = pos;
					lc   = 2 * pos + 1;
					rc   = 2 * pos + 2;
					if (lc < heap_count && heap_mem[lc].severity > heap_mem[best].severity)
						best = lc;
					if (rc < heap_count && heap_mem[rc].severity > heap_mem[best].severity)
						best = rc;
					if (best == pos)
						break;
					tmp            = heap_mem[pos];
					heap_mem[pos]  = heap_mem[best];
					heap_mem[best] = tmp;
					pos            = best;
				end
			end
		end
		r.occupancy = 8'(heap_count);
	endtask

	task automatic add_op(input logic func, input logic [15:0] task_id,
			input logic [15:0] severity, input bit settle);
		heap_op_t op;
		op.func     = func;
		op.task_id  = task_id;
		op.severity = severity;
		op.settle   = settle;
		pending_ops.push_back(op);
		if (func == FUNC_INSERT && plan_count < CAPACITY)
			plan_count++;
		else if (func == FUNC_EXTRACT && plan_count > 0)
			plan_count--;
	endtask

	function automatic logic [15:0] pick_severity(input int mode);
		case (mode)
			0: pick_severity = 16'($urandom_range(0, 7));
			1: pick_severity = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: pick_severity = 16'($urandom);
		endcase
	endfunction

	function automatic bit quiet_window();
		quiet_window = cycle_count >= QUIET_LO && cycle_count < QUIET_HI;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_heap(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16],
					predicted);
				expected_results.push_back(predicted);
				sent_count <= sent_count + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_ops.size() != 0
						&& (quiet_window() || $urandom_range(0, 99) >= 8)
						&& !(pending_ops[0].settle
							&& sent_count + (s_axis_tvalid ? 1 : 0) != done_count)) begin
					next_op = pending_ops.pop_front();
					s_axis_tdata  <= {next_op.severity, next_op.task_id};
					s_axis_tuser  <= next_op.func;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (!holdoff_done && sent_count >= HOLD_AT) begin
			holdoff_left <= HOLD_LEN;
			holdoff_done <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= holdoff_left == 0
				&& (quiet_window() || $urandom_range(0, 99) >= 8);
			if (m_axis_tvalid && m_axis_tready) begin
				done_count <= done_count + 1;
				if (expected_results.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: status %0d id %h sev %h occ %0d",
							m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
							m_axis_tdata[39:32]);
					err_count <= err_count + 1;
				end else begin
					oldest = expected_results.pop_front();
					if (m_axis_tuser !== oldest.status
							|| m_axis_tdata[15:0] !== oldest.out_id
							|| m_axis_tdata[31:16] !== oldest.out_severity
							|| m_axis_tdata[39:32] !== oldest.occupancy) begin
						if (err_count < 10) begin
							$write("result %0d: expected status %0d id %h sev %h occ %0d,",
								done_count, oldest.status, oldest.out_id,
								oldest.out_severity, oldest.occupancy);
							$display(" got status %0d id %h sev %h occ %0d", m_axis_tuser,
								m_axis_tdata[15:0], m_axis_tdata[31:16],
								m_axis_tdata[39:32]);
						end
						err_count <= err_count + 1;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int phase;
		int mode;
		int extra;
		int n;
		add_op(FUNC_EXTRACT, 16'h1111, 16'h2222, 1'b0);
		add_op(FUNC_INSERT, 16'h0000, 16'h0000, 1'b0);
		add_op(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 1'b0);
		add_op(FUNC_INSERT, 16'h1234, 16'h8000, 1'b0);
		add_op(FUNC_INSERT, 16'h0002, 16'h8000, 1'b0);
		add_op(FUNC_INSERT, 16'h0003, 16'h8000, 1'b0);
		add_op(FUNC_INSERT, 16'hFFFF, 16'h0000, 1'b0);
		add_op(FUNC_INSERT, 16'h0000, 16'hFFFF, 1'b0);
		add_op(FUNC_INSERT, 16'hA5A5, 16'h8000, 1'b0);
		for (int i = 0; i < 9; i++)
			add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b0);
		add_op(FUNC_INSERT, 16'h0010, 16'h0005, 1'b0);
		add_op(FUNC_INSERT, 16'h0011, 16'h0005, 1'b0);
		add_op(FUNC_INSERT, 16'h0012, 16'h0005, 1'b0);
		add_op(FUNC_INSERT, 16'h0013, 16'h0006, 1'b0);
		for (int i = 0; i < 4; i++)
			add_op(FUNC_EXTRACT, 16'h0000, 16'h0000, 1'b0);

		while (pending_ops.size() < NUM_OPS) begin
			phase = $urandom_range(0, 2);
			mode  = $urandom_range(0, 2);
			add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b1);
			case (phase)
				0: begin
					while (plan_count < CAPACITY) begin
						if ($urandom_range(0, 9) == 0)
							add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b0);
						else
							add_op(FUNC_INSERT, 16'($urandom), pick_severity(mode), 1'b0);
					end
					extra = $urandom_range(2, 5);
					for (int i = 0; i < extra; i++)
						add_op(FUNC_INSERT, 16'($urandom), pick_severity(mode), 1'b0);
				end
				1: begin
					while (plan_count > 0) begin
						if ($urandom_range(0, 9) == 0)
							add_op(FUNC_INSERT, 16'($urandom), pick_severity(mode), 1'b0);
						else
							add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b0);
					end
					extra = $urandom_range(1, 3);
					for (int i = 0; i < extra; i++)
						add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b0);
				end
				default: begin
					n = $urandom_range(40, 80);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 99) < 55)
							add_op(FUNC_INSERT, 16'($urandom), pick_severity(mode), 1'b0);
						else
							add_op(FUNC_EXTRACT, 16'($urandom), 16'($urandom), 1'b0);
					end
				end
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_ops.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
